[hdl/tcs_pkg.sv]
// Shared types, constants and the tricube weight table for the grid smoother.
`default_nettype none
package tcs_pkg;

    localparam int MAX_COLS      = 64;
    localparam int MAX_ROWS      = 64;
    localparam int VALUE_BITS    = 32;
    localparam int WTD           = 256;
    localparam int COL_BITS      = $clog2(MAX_COLS);
    localparam int ROW_BITS      = $clog2(MAX_ROWS);
    localparam int GRID_DEPTH    = MAX_COLS * MAX_ROWS;
    localparam int CELL_BITS     = VALUE_BITS + 1;
    localparam int WIDX_BITS     = $clog2(WTD);
    localparam int W_BITS        = 17;
    localparam int ACC_BITS      = 64;
    localparam int WSUM_BITS     = 30;
    localparam int CNT_BITS      = 6;
    localparam int CFG_ADDR_BITS = 5;

    localparam logic [W_BITS-1:0]   Q_ONE  = W_BITS'(65536);
    localparam logic [CNT_BITS-1:0] CNT_WT = CNT_BITS'(WIDX_BITS - 1);
    localparam logic [CNT_BITS-1:0] CNT_Q  = CNT_BITS'(ACC_BITS - 1);

    typedef logic [W_BITS-1:0] t_wtab [WTD];

    function automatic t_wtab build_wtab();
        t_wtab tab;
        longint unsigned q, c, tt, x, r, b;
        for (int i = 0; i < WTD; i++) begin
            q = longint'(i) * 65536 / WTD;
            x = q << 16;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            c = (q * r) >> 16;
            tt = 65536 - c;
            tab[i] = W_BITS'((tt * tt * tt) >> 32);
        end
        return tab;
    endfunction

    localparam t_wtab WEIGHT_TAB = build_wtab();

    typedef enum logic [3:0] {
        ST_IDLE, ST_CELL, ST_DEN, ST_ADDR, ST_MUL1, ST_MUL2, ST_DIV,
        ST_WT, ST_PROD, ST_ACC, ST_FCHK, ST_FDIV, ST_OUT
    } t_state;

    typedef enum logic [1:0] {SRC_WRITE, SRC_STORED, SRC_SMOOTH} t_src;

    typedef enum logic [2:0] {
        REG_COLS, REG_ROWS, REG_WRAP_C, REG_WRAP_R,
        REG_WL_C, REG_WL_R, REG_SMOOTH, REG_FILL
    } t_reg;

    typedef struct packed {
        logic [6:0] cols_used;
        logic [6:0] rows_used;
        logic       wrap_cols;
        logic       wrap_rows;
        logic [7:0] wl_cols;
        logic [7:0] wl_rows;
        logic       smooth_en;
        logic       fill_en;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic cap_center;
        logic init_win;
        logic rd_nb;
        logic cap_nb;
        logic calc_num;
        logic div_step;
        logic pick_w;
        logic mult;
        logic accum;
        logic final_init;
        logic fdiv_step;
        logic out_load;
        t_src src;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic sel;
        logic cnt_zero;
        logic win_last;
        logic wsum_zero;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

[hdl/tcs_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module tcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

[hdl/tcs_ctrl.sv]
// Sequencer for write and query requests of the grid smoother.
`default_nettype none
module tcs_ctrl import tcs_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);
    t_state r_state, n_state;
    t_src   r_src, n_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_src   <= SRC_WRITE;
        end else begin
            r_state <= n_state;
            r_src   <= n_src;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_src      = r_src;
        o_cmd      = '0;
        o_cmd.src  = r_src;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    if (i_stat.is_query) begin
                        n_state = ST_CELL;
                    end else begin
                        n_src   = SRC_WRITE;
                        n_state = ST_OUT;
                    end
                end
            end
            ST_CELL: begin
                o_cmd.cap_center = 1'b1;
                if (i_stat.sel) begin
                    n_state = ST_DEN;
                end else begin
                    n_src   = SRC_STORED;
                    n_state = ST_OUT;
                end
            end
            ST_DEN: begin
                o_cmd.init_win = 1'b1;
                n_state = ST_ADDR;
            end
            ST_ADDR: begin
                o_cmd.rd_nb = 1'b1;
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.cap_nb = 1'b1;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.calc_num = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.cnt_zero) n_state = ST_WT;
            end
            ST_WT: begin
                o_cmd.pick_w = 1'b1;
                n_state = ST_PROD;
            end
            ST_PROD: begin
                o_cmd.mult = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.accum = 1'b1;
                n_state = i_stat.win_last ? ST_FCHK : ST_ADDR;
            end
            ST_FCHK: begin
                if (i_stat.wsum_zero) begin
                    n_src   = SRC_STORED;
                    n_state = ST_OUT;
                end else begin
                    o_cmd.final_init = 1'b1;
                    n_state = ST_FDIV;
                end
            end
            ST_FDIV: begin
                o_cmd.fdiv_step = 1'b1;
                if (i_stat.cnt_zero) begin
                    n_src   = SRC_SMOOTH;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[hdl/tcs_datapath.sv]
// Grid memory, window walk, weight pipeline, accumulators and dividers.
`default_nettype none
module tcs_datapath import tcs_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  i_action,
    input  wire logic [COL_BITS-1:0]   i_col,
    input  wire logic [ROW_BITS-1:0]   i_row,
    input  wire logic [VALUE_BITS-1:0] i_sample,
    input  wire logic                  i_sample_missing,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [VALUE_BITS-1:0]      o_cell_value,
    output logic                       o_cell_missing
);
    logic [COL_BITS-1:0]   r_col;
    logic [ROW_BITS-1:0]   r_row;
    logic [VALUE_BITS-1:0] r_sample;
    logic                  r_smiss;
    logic [VALUE_BITS-1:0] r_cval;
    logic                  r_cmiss;
    logic [6:0]            r_nx, r_ny;
    logic [5:0]            r_wx, r_wy;
    logic [10:0]           r_wx2, r_wy2, r_dx2, r_dy2;
    logic                  r_wrap_c, r_wrap_r, r_dodist;
    logic [21:0]           r_den, r_num, r_p1, r_rem;
    logic signed [7:0]     r_xb, r_ya, r_yb, r_xl, r_yl;
    logic [WIDX_BITS-1:0]  r_q8;
    logic signed [VALUE_BITS-1:0] r_nval;
    logic                  r_nmiss;
    logic [W_BITS-1:0]     r_w;
    logic signed [49:0]    r_prod;
    logic signed [ACC_BITS-1:0] r_acc;
    logic [WSUM_BITS-1:0]  r_wsum;
    logic [ACC_BITS-1:0]   r_div;
    logic [WSUM_BITS-1:0]  r_rem2;
    logic                  r_neg;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_val;
    logic                  r_out_miss;

    logic [6:0]            nx, ny, hx, hy;
    logic [5:0]            wx, wy;
    logic [CELL_BITS-1:0]  rdata;
    logic [COL_BITS+ROW_BITS-1:0] addr;
    logic                  we;
    logic signed [7:0]     col8, row8, nx8, ny8, xw, yw, dxs, dys, xa0, xb0, ya0, yb0;
    logic [5:0]            dx, dy;
    logic [22:0]           dtry;
    logic [WSUM_BITS:0]    ftry;
    logic [VALUE_BITS-1:0] smooth_val;
    logic [VALUE_BITS-1:0] wr_val;

    always_comb begin
        nx = (i_cfg.cols_used == 7'd0) ? 7'd1 :
             (i_cfg.cols_used > 7'(MAX_COLS)) ? 7'(MAX_COLS) : i_cfg.cols_used;
        ny = (i_cfg.rows_used == 7'd0) ? 7'd1 :
             (i_cfg.rows_used > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : i_cfg.rows_used;
        hx = i_cfg.wl_cols[7:1];
        hy = i_cfg.wl_rows[7:1];
        wx = (hx > (nx >> 1)) ? 6'd0 : hx[5:0];
        wy = (hy > (ny >> 1)) ? 6'd0 : hy[5:0];

        col8 = signed'({2'b00, r_col});
        row8 = signed'({2'b00, r_row});
        nx8  = signed'({1'b0, r_nx});
        ny8  = signed'({1'b0, r_ny});
        xa0  = col8 - signed'({2'b00, r_wx});
        xb0  = col8 + signed'({2'b00, r_wx});
        ya0  = row8 - signed'({2'b00, r_wy});
        yb0  = row8 + signed'({2'b00, r_wy});
        if (!r_wrap_c) begin
            if (xa0 < 0) xa0 = '0;
            if (xb0 > nx8 - 8'sd1) xb0 = nx8 - 8'sd1;
        end
        if (!r_wrap_r) begin
            if (ya0 < 0) ya0 = '0;
            if (yb0 > ny8 - 8'sd1) yb0 = ny8 - 8'sd1;
        end

        xw = (r_xl < 0) ? r_xl + nx8 : (r_xl >= nx8) ? r_xl - nx8 : r_xl;
        yw = (r_yl < 0) ? r_yl + ny8 : (r_yl >= ny8) ? r_yl - ny8 : r_yl;
        dxs = r_xl - col8;
        dys = r_yl - row8;
        dx = (dxs < 0) ? 6'(-dxs) : dxs[5:0];
        dy = (dys < 0) ? 6'(-dys) : dys[5:0];

        we     = i_cmd.load_in && !i_action;
        wr_val = i_sample_missing ? VALUE_BITS'(0) : i_sample;
        addr   = i_cmd.load_in ? {i_col, i_row} :
                 {xw[COL_BITS-1:0], yw[ROW_BITS-1:0]};

        dtry = {r_rem, 1'b0};
        ftry = {r_rem2, r_div[ACC_BITS-1]};
        smooth_val = r_neg ? (~r_div[VALUE_BITS-1:0] + 1'b1) : r_div[VALUE_BITS-1:0];
    end

    tcs_ram #(.WIDTH(CELL_BITS), .DEPTH(GRID_DEPTH)) u_grid (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (addr),
        .i_wdata ({i_sample_missing, wr_val}),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_col    <= i_col;
            r_row    <= i_row;
            r_sample <= wr_val;
            r_smiss  <= i_sample_missing;
        end
        if (i_cmd.cap_center) begin
            r_cval   <= rdata[VALUE_BITS-1:0];
            r_cmiss  <= rdata[VALUE_BITS];
            r_nx     <= nx;
            r_ny     <= ny;
            r_wx     <= wx;
            r_wy     <= wy;
            r_wx2    <= 11'(wx * wx);
            r_wy2    <= 11'(wy * wy);
            r_wrap_c <= i_cfg.wrap_cols;
            r_wrap_r <= i_cfg.wrap_rows;
            r_dodist <= (wx != 6'd0) && (wy != 6'd0);
        end
        if (i_cmd.init_win) begin
            r_den  <= 22'(r_wx2 * r_wy2);
            r_xb   <= xb0;
            r_ya   <= ya0;
            r_yb   <= yb0;
            r_xl   <= xa0;
            r_yl   <= ya0;
            r_acc  <= '0;
            r_wsum <= '0;
        end
        if (i_cmd.rd_nb) begin
            r_dx2 <= 11'(dx * dx);
            r_dy2 <= 11'(dy * dy);
        end
        if (i_cmd.cap_nb) begin
            r_nval  <= signed'(rdata[VALUE_BITS-1:0]);
            r_nmiss <= rdata[VALUE_BITS];
            r_p1    <= 22'(r_dx2 * r_wy2);
        end
        if (i_cmd.calc_num) begin
            r_num <= 22'(r_p1 + r_dy2 * r_wx2);
            r_rem <= 22'(r_p1 + r_dy2 * r_wx2);
            r_q8  <= '0;
        end
        if (i_cmd.div_step) begin
            if (dtry >= {1'b0, r_den}) begin
                r_rem <= 22'(dtry - {1'b0, r_den});
                r_q8  <= {r_q8[WIDX_BITS-2:0], 1'b1};
            end else begin
                r_rem <= dtry[21:0];
                r_q8  <= {r_q8[WIDX_BITS-2:0], 1'b0};
            end
        end
        if (i_cmd.pick_w) begin
            r_w <= r_nmiss ? '0 : !r_dodist ? Q_ONE :
                   (r_num >= r_den) ? '0 : WEIGHT_TAB[r_q8];
        end
        if (i_cmd.mult) r_prod <= signed'({1'b0, r_w}) * r_nval;
        if (i_cmd.accum) begin
            r_acc  <= r_acc + ACC_BITS'(r_prod);
            r_wsum <= r_wsum + WSUM_BITS'(r_w);
            if (r_yl == r_yb) begin
                r_yl <= r_ya;
                r_xl <= r_xl + 8'sd1;
            end else begin
                r_yl <= r_yl + 8'sd1;
            end
        end
        if (i_cmd.final_init) begin
            r_neg  <= r_acc[ACC_BITS-1];
            r_div  <= r_acc[ACC_BITS-1] ? ACC_BITS'(-r_acc) : r_acc;
            r_rem2 <= '0;
        end
        if (i_cmd.fdiv_step) begin
            if (ftry >= {1'b0, r_wsum}) begin
                r_rem2 <= WSUM_BITS'(ftry - {1'b0, r_wsum});
                r_div  <= {r_div[ACC_BITS-2:0], 1'b1};
            end else begin
                r_rem2 <= ftry[WSUM_BITS-1:0];
                r_div  <= {r_div[ACC_BITS-2:0], 1'b0};
            end
        end
        if (i_cmd.calc_num)        r_cnt <= CNT_WT;
        else if (i_cmd.final_init) r_cnt <= CNT_Q;
        else if (i_cmd.div_step || i_cmd.fdiv_step) r_cnt <= r_cnt - 1'b1;
        if (i_cmd.out_load) begin
            case (i_cmd.src)
                SRC_WRITE: begin
                    r_out_val  <= r_sample;
                    r_out_miss <= r_smiss;
                end
                SRC_STORED: begin
                    r_out_val  <= r_cmiss ? '0 : r_cval;
                    r_out_miss <= r_cmiss;
                end
                default: begin
                    r_out_val  <= smooth_val;
                    r_out_miss <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_stat.is_query  = i_action;
        o_stat.sel       = ({1'b0, r_col} < nx) && ({1'b0, r_row} < ny) &&
                           ((i_cfg.smooth_en && !rdata[VALUE_BITS]) ||
                            (i_cfg.fill_en && rdata[VALUE_BITS]));
        o_stat.cnt_zero  = (r_cnt == '0);
        o_stat.win_last  = (r_xl == r_xb) && (r_yl == r_yb);
        o_stat.wsum_zero = (r_wsum == '0);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_cell_value   = r_out_val;
    assign o_cell_missing = r_out_miss;
endmodule
`default_nettype wire

[hdl/tricube_grid_smoother.sv]
// Top level: configuration registers, stream ports, controller and datapath.
// Write requests return the input sample and unsmoothed queries the stored cell; both skip the window.
// Smoothed query: the N window cells (N up to 65*65) are walked one at a time; the time per cell
// comes from the single grid memory port, the 8-step index divider and the multiply chain,
// and a bit-serial final divider follows the walk. One request is in work at a time.
// Reset restores register defaults; the grid memory is undefined until written.
`default_nettype none
module tricube_grid_smoother import tcs_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // col[5:0], row[11:6], sample[43:12], zero pad
    input  wire logic [47:0]              i_s_axis_tdata,
    // action[0], sample_missing[1]
    input  wire logic [1:0]               i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  wire logic                     i_m_axis_tready,
    // cell_value[31:0]
    output logic [31:0]                   o_m_axis_tdata,
    // cell_missing[0]
    output logic                          o_m_axis_tuser,
    input  wire logic                     i_psel,
    input  wire logic                     i_penable,
    input  wire logic                     i_pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] i_paddr,
    input  wire logic [31:0]              i_pwdata,
    output logic [31:0]                   o_prdata,
    output logic                          o_pready
);
    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;
    t_reg  reg_idx;

    assign reg_idx  = t_reg'(i_paddr[4:2]);
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cols_used <= 7'd64;
            r_cfg.rows_used <= 7'd64;
            r_cfg.wrap_cols <= 1'b0;
            r_cfg.wrap_rows <= 1'b0;
            r_cfg.wl_cols   <= 8'd0;
            r_cfg.wl_rows   <= 8'd0;
            r_cfg.smooth_en <= 1'b1;
            r_cfg.fill_en   <= 1'b0;
        end else if (i_psel && i_penable && i_pwrite) begin
            unique case (reg_idx)
                REG_COLS:   r_cfg.cols_used <= i_pwdata[6:0];
                REG_ROWS:   r_cfg.rows_used <= i_pwdata[6:0];
                REG_WRAP_C: r_cfg.wrap_cols <= i_pwdata[0];
                REG_WRAP_R: r_cfg.wrap_rows <= i_pwdata[0];
                REG_WL_C:   r_cfg.wl_cols   <= i_pwdata[7:0];
                REG_WL_R:   r_cfg.wl_rows   <= i_pwdata[7:0];
                REG_SMOOTH: r_cfg.smooth_en <= i_pwdata[0];
                REG_FILL:   r_cfg.fill_en   <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_COLS:   o_prdata = {25'd0, r_cfg.cols_used};
            REG_ROWS:   o_prdata = {25'd0, r_cfg.rows_used};
            REG_WRAP_C: o_prdata = {31'd0, r_cfg.wrap_cols};
            REG_WRAP_R: o_prdata = {31'd0, r_cfg.wrap_rows};
            REG_WL_C:   o_prdata = {24'd0, r_cfg.wl_cols};
            REG_WL_R:   o_prdata = {24'd0, r_cfg.wl_rows};
            REG_SMOOTH: o_prdata = {31'd0, r_cfg.smooth_en};
            REG_FILL:   o_prdata = {31'd0, r_cfg.fill_en};
            default:    o_prdata = '0;
        endcase
    end

    tcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tcs_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_action         (i_s_axis_tuser[0]),
        .i_col            (i_s_axis_tdata[5:0]),
        .i_row            (i_s_axis_tdata[11:6]),
        .i_sample         (i_s_axis_tdata[43:12]),
        .i_sample_missing (i_s_axis_tuser[1]),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_out_valid      (o_m_axis_tvalid),
        .i_out_ready      (i_m_axis_tready),
        .o_cell_value     (o_m_axis_tdata),
        .o_cell_missing   (o_m_axis_tuser)
    );
endmodule
`default_nettype wire
